// ===== rtl/dtsi_pkg.sv =====
// shared types, character codes and constants for the decimal text to scaled integer block
package dtsi_pkg;

	// default longest accepted number string, in characters
	localparam int unsigned MAX_CHARS_DEF = 8;

	// depth of the queue between front and back
	localparam int unsigned QUEUE_DEPTH = 2;

	// ascii codes
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;
	localparam logic [7:0] CH_DOT  = 8'h2E;

	// value reported for a malformed number
	localparam logic [31:0] BAD_VALUE = 32'hFFFF_FFFF;

	// reciprocal of ten: floor(x * RECIP_TEN / 2^RECIP_SHIFT) == x / 10 for any 32-bit x
	localparam logic [63:0] RECIP_TEN   = 64'h0000_0000_CCCC_CCCD;
	localparam int unsigned RECIP_SHIFT = 35;

	// character class decided by the front
	typedef enum logic [1:0] {
		KIND_DIGIT,
		KIND_DOT,
		KIND_BAD
	} char_kind_t;

	// result status codes
	typedef enum logic [1:0] {
		STATUS_OK         = 2'd0,
		STATUS_BAD_FORMAT = 2'd1,
		STATUS_TOO_LONG   = 2'd2
	} status_t;

	// classified character as queued between front and back
	typedef struct packed {
		char_kind_t  kind;
		logic [3:0]  digit;
		logic        last;
	} char_item_t;

	// back end sequencer states
	typedef enum logic [1:0] {
		ST_ACC,
		ST_SCALE,
		ST_EMIT
	} back_state_t;

endpackage

// ===== rtl/dtsi_front.sv =====
// front end: takes characters in and classifies them into digit, dot or bad
module dtsi_front
	import dtsi_pkg::*;
(
	input  logic        s_valid,
	output logic        s_ready,
	input  logic [7:0]  text_char,
	input  logic        last,
	input  logic        queue_full,
	output logic        push,
	output char_item_t  item
);

	// take a request whenever the queue has room
	assign s_ready = !queue_full;
	assign push    = s_valid && !queue_full;

	// classify the character
	always_comb begin
		item.last  = last;
		item.digit = 4'(text_char - CH_ZERO);
		if ((text_char >= CH_ZERO) && (text_char <= CH_NINE)) begin
			item.kind = KIND_DIGIT;
		end else if (text_char == CH_DOT) begin
			item.kind = KIND_DOT;
		end else begin
			item.kind = KIND_BAD;
		end
	end

endmodule

// ===== rtl/dtsi_queue.sv =====
// short queue of classified characters between front and back
module dtsi_queue
	import dtsi_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  char_item_t  push_item,
	output logic        full,
	input  logic        pop,
	output logic        not_empty,
	output char_item_t  head_item
);

	localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

	char_item_t        slots_q [QUEUE_DEPTH];
	logic [PtrW-1:0]   wr_ptr_q;
	logic [PtrW-1:0]   rd_ptr_q;
	logic [CntW-1:0]   count_q;
	logic              do_push;
	logic              do_pop;

	assign full      = (count_q == CntW'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign head_item = slots_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= push_item;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!do_push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/dtsi_back.sv =====
// back end: accumulates digits, checks format and rescales by powers of ten
module dtsi_back
	import dtsi_pkg::*;
#(
	parameter int unsigned MAX_CHARS = MAX_CHARS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic [3:0]  cfg_places,
	input  logic        item_valid,
	input  char_item_t  item,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] out_value,
	output status_t     out_status
);

	localparam int unsigned CntW = $clog2(MAX_CHARS + 2);

	back_state_t      state_q;
	back_state_t      state_n;
	logic [3:0]       places_q;

	// number being read
	logic [31:0]      acc_q;
	logic [CntW-1:0]  cnt_q;
	logic [1:0]       dots_q;
	logic [3:0]       frac_q;
	logic             bad_q;
	logic [31:0]      acc_n;
	logic [CntW-1:0]  cnt_n;
	logic [1:0]       dots_n;
	logic [3:0]       frac_n;
	logic             bad_n;

	// rescale unit
	logic [31:0]      work_q;
	logic [3:0]       steps_q;
	logic             up_q;
	status_t          status_q;
	logic [31:0]      times_ten;
	logic [63:0]      recip_prod;
	logic [31:0]      div_ten;

	// finishing decision
	logic             too_long;
	logic             bad_format;
	logic             scale_up;
	logic [3:0]       steps_n;
	logic             take_last;
	logic             load_out;

	// output register
	logic             out_valid_q;
	logic [31:0]      out_value_q;
	status_t          out_status_q;

	// number state after the popped character
	always_comb begin
		acc_n  = acc_q;
		dots_n = dots_q;
		frac_n = frac_q;
		bad_n  = bad_q;
		cnt_n  = (cnt_q < CntW'(MAX_CHARS + 1)) ? cnt_q + 1'b1 : cnt_q;
		unique case (item.kind)
			KIND_DIGIT: begin
				acc_n = (acc_q << 3) + (acc_q << 1) + 32'(item.digit);
				if ((dots_q == 2'd1) && (frac_q != 4'hF)) begin
					frac_n = frac_q + 1'b1;
				end
			end
			KIND_DOT: begin
				if (dots_q != 2'd2) begin
					dots_n = dots_q + 1'b1;
				end
			end
			default: begin
				bad_n = 1'b1;
			end
		endcase
	end

	// classify the finished number and work out the rescale
	assign too_long   = (cnt_n > CntW'(MAX_CHARS));
	assign bad_format = bad_n || (dots_n == 2'd2);
	assign scale_up   = (places_q > frac_n);
	assign steps_n    = scale_up ? (places_q - frac_n) : (frac_n - places_q);

	// one multiply or divide by ten per cycle
	assign times_ten  = (work_q << 3) + (work_q << 1);
	assign recip_prod = 64'(work_q) * RECIP_TEN;
	assign div_ten    = 32'(recip_prod >> RECIP_SHIFT);

	// next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_ACC: begin
				if (item_valid && item.last) begin
					if (!too_long && !bad_format && (steps_n != '0)) begin
						state_n = ST_SCALE;
					end else begin
						state_n = ST_EMIT;
					end
				end
			end
			ST_SCALE: begin
				if (steps_q == 4'd1) begin
					state_n = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (!out_valid_q || out_ready) begin
					state_n = ST_ACC;
				end
			end
			default: state_n = ST_ACC;
		endcase
	end

	// sequencer outputs
	always_comb begin
		pop      = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			ST_ACC:   pop = item_valid;
			ST_SCALE: ;
			ST_EMIT:  load_out = !out_valid_q || out_ready;
			default:  ;
		endcase
	end

	assign take_last = pop && item.last;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_ACC;
			places_q    <= '0;
			acc_q       <= '0;
			cnt_q       <= '0;
			dots_q      <= '0;
			frac_q      <= '0;
			bad_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cfg_write) begin
				places_q <= cfg_places;
			end
			if (take_last) begin
				acc_q  <= '0;
				cnt_q  <= '0;
				dots_q <= '0;
				frac_q <= '0;
				bad_q  <= 1'b0;
			end else if (pop) begin
				acc_q  <= acc_n;
				cnt_q  <= cnt_n;
				dots_q <= dots_n;
				frac_q <= frac_n;
				bad_q  <= bad_n;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// rescale work and result payload
	always_ff @(posedge clk) begin
		if (take_last) begin
			up_q    <= scale_up;
			steps_q <= steps_n;
			priority if (too_long) begin
				work_q   <= '0;
				status_q <= STATUS_TOO_LONG;
			end else if (bad_format) begin
				work_q   <= BAD_VALUE;
				status_q <= STATUS_BAD_FORMAT;
			end else begin
				work_q   <= acc_n;
				status_q <= STATUS_OK;
			end
		end else if (state_q == ST_SCALE) begin
			work_q  <= up_q ? times_ten : div_ten;
			steps_q <= steps_q - 1'b1;
		end
		if (load_out) begin
			out_value_q  <= work_q;
			out_status_q <= status_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_value  = out_value_q;
	assign out_status = out_status_q;

endmodule

// ===== rtl/decimal_text_to_scaled_integer_top.sv =====
// Top level of the ascii decimal text to scaled integer converter.
// Throughput: one character per cycle while the queue has room; after the last character of a number the back end
// rescales it in k steps, k = |decimal_places - fraction digits| (0..15), one x10 or /10 each, then emits it.
// The two-entry queue lets up to two characters of the next number arrive while the back end is busy.
// Reset: asynchronous active low; clears the number in progress, decimal_places and the output.
module decimal_text_to_scaled_integer_top
	import dtsi_pkg::*;
#(
	parameter int unsigned MAX_CHARS = MAX_CHARS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration: decimal_places
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_data,
	// input characters
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] text_char
	input  logic        s_axis_tlast,
	// results
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [31:0] value
	output logic [1:0]  m_axis_tuser    // [1:0] status
);

	logic        queue_full;
	logic        push;
	char_item_t  push_item;
	logic        pop;
	logic        not_empty;
	char_item_t  head_item;
	status_t     status;

	// register writes are always taken
	assign cfg_ready = 1'b1;

	dtsi_front u_front (
		.s_valid    (s_axis_tvalid),
		.s_ready    (s_axis_tready),
		.text_char  (s_axis_tdata),
		.last       (s_axis_tlast),
		.queue_full (queue_full),
		.push       (push),
		.item       (push_item)
	);

	dtsi_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.full       (queue_full),
		.pop        (pop),
		.not_empty  (not_empty),
		.head_item  (head_item)
	);

	dtsi_back #(
		.MAX_CHARS (MAX_CHARS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_write  (cfg_valid && cfg_ready),
		.cfg_places (cfg_data),
		.item_valid (not_empty),
		.item       (head_item),
		.pop        (pop),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_value  (m_axis_tdata),
		.out_status (status)
	);

	assign m_axis_tuser = 2'(status);

endmodule

// ===== rtl/dtsi_checker.sv =====
// port level checks for the converter, bound to the top level
module dtsi_checker
	import dtsi_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [31:0] m_axis_tdata,
	input  logic [1:0]  m_axis_tuser
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result changed while stalled");

	// malformed number reports all ones
	a_bad_value: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == 2'(STATUS_BAD_FORMAT)) |-> m_axis_tdata == BAD_VALUE)
		else $error("bad format without all-ones value");

	// overlong number reports zero
	a_long_value: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == 2'(STATUS_TOO_LONG)) |-> m_axis_tdata == '0)
		else $error("too long without zero value");

	// no undefined status code
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tuser == 2'(STATUS_OK)) ||
			(m_axis_tuser == 2'(STATUS_BAD_FORMAT)) || (m_axis_tuser == 2'(STATUS_TOO_LONG)))
		else $error("undefined status code");

endmodule

bind decimal_text_to_scaled_integer_top dtsi_checker u_dtsi_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

// ===== tb/tb.sv =====
// self-checking testbench for the decimal text to scaled integer converter
`timescale 1ns / 100ps

module tb;
	import dtsi_pkg::*;

	// one character request as queued for the driver
	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} char_req_t;

	// one scaled number as the block should report it
	typedef struct packed {
		logic [31:0] value;
		status_t     status;
	} scaled_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [3:0]  cfg_data = 4'd0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'd0;   // [7:0] text_char
	logic        s_axis_tlast = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;          // [31:0] value
	logic [1:0]  m_axis_tuser;          // [1:0] status

	decimal_text_to_scaled_integer_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	char_req_t   text_chars[$];
	scaled_t     due_numbers[$];

	// shadow of the converter state
	logic [3:0]  places_cfg = 4'd0;
	logic [31:0] digit_acc = 32'd0;
	logic [3:0]  chars_seen = 4'd0;
	logic [1:0]  dots_seen = 2'd0;
	logic [3:0]  frac_seen = 4'd0;
	logic        junk_seen = 1'b0;

	int unsigned src_gap_max = 0;
	int unsigned snk_gap_max = 0;
	int unsigned src_wait = 0;
	int unsigned snk_wait = 0;
	int unsigned fail_count = 0;
	logic        hold_go = 1'b0;
	logic        hold_on = 1'b0;

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// run limit
	initial begin
		#5_000_000;
		$display("decimal_text_to_scaled_integer_top: mismatch");
		$finish;
	end

	// ten to the power n, wrapping at 32 bits
	function automatic logic [31:0] ten_pow(input logic [3:0] n);
		logic [31:0] p;
		p = 32'd1;
		for (int i = 0; i < n; i++)
			p = p * 32'd10;
		return p;
	endfunction

	// fold one accepted character into the shadow state, queue the number on last
	task automatic convert_char(input logic [7:0] c, input logic is_last);
		scaled_t r;
		if (chars_seen < MAX_CHARS_DEF + 1)
			chars_seen = chars_seen + 4'd1;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			digit_acc = digit_acc * 32'd10 + {24'd0, c - CH_ZERO};
			if (dots_seen == 2'd1 && frac_seen < 4'd15)
				frac_seen = frac_seen + 4'd1;
		end else if (c == CH_DOT) begin
			if (dots_seen < 2'd2)
				dots_seen = dots_seen + 2'd1;
		end else begin
			junk_seen = 1'b1;
		end
		if (is_last) begin
			if (chars_seen > MAX_CHARS_DEF) begin
				r.value = 32'd0;
				r.status = STATUS_TOO_LONG;
			end else if (junk_seen || dots_seen >= 2'd2) begin
				r.value = BAD_VALUE;
				r.status = STATUS_BAD_FORMAT;
			end else begin
				r.value = digit_acc;
				if (places_cfg > frac_seen)
					r.value = r.value * ten_pow(places_cfg - frac_seen);
				else if (places_cfg < frac_seen)
					r.value = r.value / ten_pow(frac_seen - places_cfg);
				r.status = STATUS_OK;
			end
			due_numbers.push_back(r);
			digit_acc = 32'd0;
			chars_seen = 4'd0;
			dots_seen = 2'd0;
			frac_seen = 4'd0;
			junk_seen = 1'b0;
		end
	endtask

	// character driver
	always @(posedge clk or negedge arst_n) begin : drv
		char_req_t req;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= 8'd0;
			s_axis_tlast <= 1'b0;
			src_wait = 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				convert_char(s_axis_tdata, s_axis_tlast);
			if (!s_axis_tvalid || s_axis_tready) begin
				if (src_wait != 0) begin
					src_wait--;
					s_axis_tvalid <= 1'b0;
				end else if (text_chars.size() != 0) begin
					req = text_chars.pop_front();
					s_axis_tdata <= req.ch;
					s_axis_tlast <= req.last;
					s_axis_tvalid <= 1'b1;
					src_wait = $urandom_range(0, src_gap_max);
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off so the input side backs up
	initial begin
		wait (hold_go);
		@(posedge clk);
		hold_on <= 1'b1;
		repeat (400) @(posedge clk);
		hold_on <= 1'b0;
	end

	// result monitor and checker
	always @(posedge clk or negedge arst_n) begin : mon
		scaled_t got;
		scaled_t want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			snk_wait = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.value = m_axis_tdata;
				got.status = status_t'(m_axis_tuser);
				if (due_numbers.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result value %h status %0d", got.value,
							got.status);
				end else begin
					want = due_numbers.pop_front();
					if (got.value !== want.value || got.status !== want.status) begin
						fail_count++;
						if (fail_count <= 10)
							$display("expected value %h status %0d, got value %h status %0d",
								want.value, want.status, got.value, got.status);
					end
				end
				snk_wait = $urandom_range(0, snk_gap_max);
			end else if (snk_wait != 0 && !hold_on) begin
				snk_wait--;
			end
			m_axis_tready <= !hold_on && snk_wait == 0;
		end
	end

	task automatic queue_char(input logic [7:0] c, input logic l);
		char_req_t req;
		req.ch = c;
		req.last = l;
		text_chars.push_back(req);
	endtask

	task automatic queue_text(input string s);
		for (int i = 0; i < s.len(); i++)
			queue_char(s[i], i == s.len() - 1);
	endtask

	// one random number string, mostly well formed; returns its length
	task automatic queue_random_number(output int unsigned len);
		int unsigned kind;
		int unsigned dot_at;
		int unsigned spoil_at;
		logic [7:0] c;
		kind = $urandom_range(0, 99);
		if (kind < 80)
			len = $urandom_range(1, MAX_CHARS_DEF);
		else if (kind < 88)
			len = $urandom_range(MAX_CHARS_DEF + 1, MAX_CHARS_DEF + 8);
		else
			len = $urandom_range(1, MAX_CHARS_DEF + 2);
		// position len means no dot
		dot_at = ($urandom_range(0, 3) == 0) ? len : $urandom_range(0, len - 1);
		spoil_at = $urandom_range(0, len - 1);
		for (int unsigned i = 0; i < len; i++) begin
			if (i == dot_at)
				c = CH_DOT;
			else
				c = CH_ZERO + 8'($urandom_range(0, 9));
			// corrupted numbers: a stray byte or a second dot
			if (kind >= 70 && kind < 80 && i == spoil_at)
				c = ($urandom_range(0, 1) == 0) ? CH_DOT : 8'($urandom_range(0, 255));
			// noise: any byte anywhere
			if (kind >= 88 && $urandom_range(0, 1) == 0)
				c = 8'($urandom_range(0, 255));
			queue_char(c, i == len - 1);
		end
	endtask

	task automatic write_places(input logic [3:0] p);
		@(posedge clk);
		cfg_data <= p;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		places_cfg = p;
	endtask

	// wait until every request is in and every number is out, then let the back end settle
	task automatic wait_drained();
		while (text_chars.size() != 0 || s_axis_tvalid || due_numbers.size() != 0)
			@(posedge clk);
		repeat (24) @(posedge clk);
	endtask

	// stimulus sequence
	initial begin : stim
		logic [3:0] place_list[10];
		int unsigned n;
		int unsigned len;
		place_list = '{4'd9, 4'd15, 4'd0, 4'd4, 4'd12, 4'd0, 4'd0, 4'd1, 4'd9, 4'd2};
		place_list[5] = 4'($urandom_range(0, 15));
		place_list[6] = 4'($urandom_range(0, 15));
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed numbers at the reset setting of zero places
		src_gap_max = 3;
		snk_gap_max = 3;
		queue_text("7");
		queue_text("99999999");
		queue_text(".5");
		queue_text("5.");
		queue_text(".");
		queue_text("..");
		queue_text("/");
		queue_text(":");
		queue_char(8'hFF, 1'b1);
		// too long wins over the bad character
		queue_text("1234567x9");
		wait_drained();

		// random phases over a range of settings
		for (int ph = 0; ph < 10; ph++) begin
			write_places(place_list[ph]);
			@(negedge clk);
			src_gap_max = (ph % 3 == 1) ? 0 : 14;
			snk_gap_max = (ph % 4 == 2) ? 0 : 14;
			if (ph == 8) begin
				src_gap_max = 0;
				hold_go = 1'b1;
			end
			n = 0;
			while (n < 110) begin
				queue_random_number(len);
				n += len;
			end
			wait_drained();
		end

		if (fail_count == 0)
			$display("decimal_text_to_scaled_integer_top: match");
		else
			$display("decimal_text_to_scaled_integer_top: mismatch");
		$finish;
	end

endmodule
